FILE: rtl/bpc_pkg.sv
// Package: shared constants, types and helpers for the pressure compensation pipeline.
package bpc_pkg;

    localparam int DIV_LAT = 32;

    localparam logic [31:0] C_B6_OFS   = 32'd4000;
    localparam logic [31:0] C_P_SCALE  = 32'd50000;
    localparam logic [31:0] C_X1_GAIN  = 32'd3038;
    localparam logic [31:0] C_X2_GAIN  = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_OFS    = 32'd3791;
    localparam logic [31:0] C_B4_BIAS  = 32'd32768;

    typedef enum logic [2:0] {
        REG_AC123 = 3'd0,
        REG_AC456 = 3'd1,
        REG_B12   = 3'd2,
        REG_MCMD  = 3'd3,
        REG_OSS   = 3'd4
    } cfg_idx_t;

    // per-item context that rides along the pipeline
    typedef struct packed {
        logic        fault;
        logic [18:0] up;
        logic [31:0] b5;
    } ctx_t;

    // signed divide by 2^n, truncating toward zero, on a 32-bit word
    function automatic logic [31:0] tdiv2(input logic [31:0] a, input int n);
        logic [31:0] mag;
        logic [31:0] shf;
        mag   = a[31] ? (~a + 32'd1) : a;
        shf   = mag >> n;
        tdiv2 = a[31] ? (~shf + 32'd1) : shf;
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] a);
        abs32 = a[31] ? (~a + 32'd1) : a;
    endfunction

endpackage

FILE: rtl/bpc_udiv.sv
// Module: pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
module bpc_udiv (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);

    logic [31:0] n_reg [0:bpc_pkg::DIV_LAT-1];
    logic [31:0] d_reg [0:bpc_pkg::DIV_LAT-1];
    logic [31:0] r_reg [0:bpc_pkg::DIV_LAT-1];
    logic [31:0] q_reg [0:bpc_pkg::DIV_LAT-1];

    for (genvar s = 0; s < bpc_pkg::DIV_LAT; s++) begin : g_stage
        logic [31:0] n_in;
        logic [31:0] d_in;
        logic [31:0] r_in;
        logic [31:0] q_in;
        logic [32:0] trial;
        logic [32:0] diff;
        logic        ge;

        if (s == 0) begin : g_first
            assign n_in = num;
            assign d_in = den;
            assign r_in = 32'd0;
            assign q_in = 32'd0;
        end else begin : g_rest
            assign n_in = n_reg[s-1];
            assign d_in = d_reg[s-1];
            assign r_in = r_reg[s-1];
            assign q_in = q_reg[s-1];
        end

        assign trial = {r_in, n_in[bpc_pkg::DIV_LAT-1-s]};
        assign diff  = trial - {1'b0, d_in};
        assign ge    = !diff[32];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s] <= n_in;
                d_reg[s] <= d_in;
                r_reg[s] <= ge ? diff[31:0] : trial[31:0];
                q_reg[s] <= {q_in[30:0], ge};
            end
        end
    end

    assign quo = q_reg[bpc_pkg::DIV_LAT-1];

endmodule

FILE: rtl/barometric_pressure_compensation_unit.sv
// Top level: barometric pressure compensation, fully pipelined datapath.
//
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------
//  in      | in_valid / in_stall     | raw_temperature, raw_pressure
//  out     | out_valid / out_stall   | temp_term, pressure_pa, divide_fault
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data (always ready)
//
// One transaction per cycle is taken unless the pipeline is frozen; the path runs
// through the two 32-stage bit-per-stage dividers (b5 division and the final
// pressure division) and 15 arithmetic stages with up to three 32x32 multiplies each.
// Reset clears valid bits and configuration registers (all coefficients zero).
// The whole pipeline freezes while a result sits in the output register and
// out_stall is high; in_stall is raised for exactly those cycles.
module barometric_pressure_compensation_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] raw_temperature,
    input  logic [18:0] raw_pressure,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] temp_term,
    output logic [31:0] pressure_pa,
    output logic        divide_fault,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    // ---------------- configuration ----------------
    logic [47:0] ac123_reg;
    logic [47:0] ac456_reg;
    logic [31:0] b12_reg;
    logic [31:0] mcmd_reg;
    logic [1:0]  oss_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac123_reg <= '0;
            ac456_reg <= '0;
            b12_reg   <= '0;
            mcmd_reg  <= '0;
            oss_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bpc_pkg::REG_AC123: ac123_reg <= cfg_data;
                bpc_pkg::REG_AC456: ac456_reg <= cfg_data;
                bpc_pkg::REG_B12:   b12_reg   <= cfg_data[31:0];
                bpc_pkg::REG_MCMD:  mcmd_reg  <= cfg_data[31:0];
                bpc_pkg::REG_OSS:   oss_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic [15:0] ac4, ac5, ac6;
    assign ac1 = bpc_pkg::sx16(ac123_reg[15:0]);
    assign ac2 = bpc_pkg::sx16(ac123_reg[31:16]);
    assign ac3 = bpc_pkg::sx16(ac123_reg[47:32]);
    assign ac4 = ac456_reg[15:0];
    assign ac5 = ac456_reg[31:16];
    assign ac6 = ac456_reg[47:32];
    assign b1  = bpc_pkg::sx16(b12_reg[15:0]);
    assign b2  = bpc_pkg::sx16(b12_reg[31:16]);
    assign mc  = bpc_pkg::sx16(mcmd_reg[15:0]);
    assign md  = bpc_pkg::sx16(mcmd_reg[31:16]);

    // ---------------- pipeline control ----------------
    // single enable: every stage moves together unless the output is held
    logic en;
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // valid bits per stage (stage 15 is the output register)
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic v9_reg, v10_reg, v11_reg, v12_reg, v13_reg, v14_reg, v15_reg;
    logic d1v_reg [0:bpc_pkg::DIV_LAT-1];
    logic d2v_reg [0:bpc_pkg::DIV_LAT-1];

    bpc_pkg::ctx_t c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c7_reg;
    bpc_pkg::ctx_t c8_reg, c9_reg, c10_reg, c11_reg, c12_reg, c13_reg, c14_reg;
    bpc_pkg::ctx_t d1c_reg [0:bpc_pkg::DIV_LAT-1];
    bpc_pkg::ctx_t d2c_reg [0:bpc_pkg::DIV_LAT-1];

    // stage 1: x1 product (ut - ac6) * ac5
    logic [31:0] prod1_reg;
    // stage 2: x1, divider operands
    logic [31:0] x1_2_reg, nabs_reg, dabs_reg;
    logic        sgn_reg;
    logic [31:0] d1x1_reg [0:bpc_pkg::DIV_LAT-1];
    logic        d1s_reg  [0:bpc_pkg::DIV_LAT-1];
    // stage 4..10
    logic [31:0] b6_reg;
    logic [31:0] sqp_reg, a2p_reg, a3p_reg;
    logic [31:0] sq_reg, x2_6_reg, x1b_6_reg;
    logic [31:0] b2sq_reg, b1sq_reg, x2_7_reg, x1b_7_reg;
    logic [31:0] x3a_reg, x3b_reg;
    logic [31:0] b3_reg, b4p_reg;
    logic [31:0] b4_reg, b7_reg;
    logic        d2m_reg [0:bpc_pkg::DIV_LAT-1];
    // stage 11..15
    logic [31:0] p11_reg, p12_reg, p13_reg, p14_reg;
    logic [31:0] t_reg, m2_12_reg, m2_13_reg, m2_14_reg;
    logic [31:0] x1a_reg, x1c_reg;
    logic [31:0] temp_reg, pres_reg;
    logic        fault_reg;

    // combinational helpers
    logic [31:0] x1_s2, den_s2, num_s2;
    logic [31:0] uq1, q1, b5_s3;
    logic [31:0] x3b_sum, b3_pre, b3_shift, scale, b4_s10;
    logic [31:0] div2_num, uq2;
    logic [31:0] sum_s15, pn_s15;

    assign x1_s2  = bpc_pkg::tdiv2(prod1_reg, 15);
    assign den_s2 = x1_s2 + md;
    assign num_s2 = mc << 11;

    bpc_udiv u_div_t (
        .clk (clk),
        .en  (en),
        .num (nabs_reg),
        .den (dabs_reg),
        .quo (uq1)
    );

    assign q1    = d1s_reg[bpc_pkg::DIV_LAT-1] ? (~uq1 + 32'd1) : uq1;
    assign b5_s3 = d1x1_reg[bpc_pkg::DIV_LAT-1] + q1;

    assign x3b_sum  = bpc_pkg::tdiv2(b1sq_reg, 16) + x1b_7_reg + 32'd2;
    assign b3_pre   = (ac1 << 2) + x3a_reg;
    assign b3_shift = b3_pre << oss_reg;
    assign scale    = bpc_pkg::C_P_SCALE >> oss_reg;
    assign b4_s10   = b4p_reg >> 15;

    // numerator doubled up front unless that would overflow
    assign div2_num = b7_reg[31] ? b7_reg : (b7_reg << 1);

    bpc_udiv u_div_p (
        .clk (clk),
        .en  (en),
        .num (div2_num),
        .den (b4_reg),
        .quo (uq2)
    );

    assign sum_s15 = bpc_pkg::tdiv2(x1c_reg, 16) + bpc_pkg::tdiv2(m2_14_reg, 16)
                   + bpc_pkg::C_P_OFS;
    assign pn_s15  = p14_reg + bpc_pkg::tdiv2(sum_s15, 4);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0; v2_reg  <= 1'b0; v3_reg  <= 1'b0; v4_reg  <= 1'b0;
            v5_reg  <= 1'b0; v6_reg  <= 1'b0; v7_reg  <= 1'b0; v8_reg  <= 1'b0;
            v9_reg  <= 1'b0; v10_reg <= 1'b0; v11_reg <= 1'b0; v12_reg <= 1'b0;
            v13_reg <= 1'b0; v14_reg <= 1'b0; v15_reg <= 1'b0;
            for (int i = 0; i < bpc_pkg::DIV_LAT; i++)
            begin
                d1v_reg[i] <= 1'b0;
                d2v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v1_reg     <= in_valid;
            v2_reg     <= v1_reg;
            d1v_reg[0] <= v2_reg;
            for (int i = 1; i < bpc_pkg::DIV_LAT; i++)
            begin
                d1v_reg[i] <= d1v_reg[i-1];
                d2v_reg[i] <= d2v_reg[i-1];
            end
            v3_reg     <= d1v_reg[bpc_pkg::DIV_LAT-1];
            v4_reg     <= v3_reg;
            v5_reg     <= v4_reg;
            v6_reg     <= v5_reg;
            v7_reg     <= v6_reg;
            v8_reg     <= v7_reg;
            v9_reg     <= v8_reg;
            v10_reg    <= v9_reg;
            d2v_reg[0] <= v10_reg;
            v11_reg    <= d2v_reg[bpc_pkg::DIV_LAT-1];
            v12_reg    <= v11_reg;
            v13_reg    <= v12_reg;
            v14_reg    <= v13_reg;
            v15_reg    <= v14_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            prod1_reg <= ({16'd0, raw_temperature} - {16'd0, ac6}) * {16'd0, ac5};
            c1_reg    <= '{fault: 1'b0, up: raw_pressure, b5: 32'd0};

            // stage 2: signed divide prepared as magnitudes
            x1_2_reg <= x1_s2;
            nabs_reg <= bpc_pkg::abs32(num_s2);
            dabs_reg <= bpc_pkg::abs32(den_s2);
            sgn_reg  <= num_s2[31] ^ den_s2[31];
            c2_reg   <= '{fault: (den_s2 == 32'd0), up: c1_reg.up, b5: 32'd0};

            // sideband alongside the first divider
            d1c_reg[0]  <= c2_reg;
            d1x1_reg[0] <= x1_2_reg;
            d1s_reg[0]  <= sgn_reg;
            for (int i = 1; i < bpc_pkg::DIV_LAT; i++)
            begin
                d1c_reg[i]  <= d1c_reg[i-1];
                d1x1_reg[i] <= d1x1_reg[i-1];
                d1s_reg[i]  <= d1s_reg[i-1];
                d2c_reg[i]  <= d2c_reg[i-1];
                d2m_reg[i]  <= d2m_reg[i-1];
            end

            // stage 3: b5
            c3_reg <= '{fault: d1c_reg[bpc_pkg::DIV_LAT-1].fault,
                        up:    d1c_reg[bpc_pkg::DIV_LAT-1].up,
                        b5:    b5_s3};

            // stage 4: b6
            b6_reg <= c3_reg.b5 - bpc_pkg::C_B6_OFS;
            c4_reg <= c3_reg;

            // stage 5: products on b6
            sqp_reg <= b6_reg * b6_reg;
            a2p_reg <= ac2 * b6_reg;
            a3p_reg <= ac3 * b6_reg;
            c5_reg  <= c4_reg;

            // stage 6
            sq_reg    <= bpc_pkg::tdiv2(sqp_reg, 12);
            x2_6_reg  <= bpc_pkg::tdiv2(a2p_reg, 11);
            x1b_6_reg <= bpc_pkg::tdiv2(a3p_reg, 13);
            c6_reg    <= c5_reg;

            // stage 7
            b2sq_reg  <= b2 * sq_reg;
            b1sq_reg  <= b1 * sq_reg;
            x2_7_reg  <= x2_6_reg;
            x1b_7_reg <= x1b_6_reg;
            c7_reg    <= c6_reg;

            // stage 8
            x3a_reg <= bpc_pkg::tdiv2(b2sq_reg, 11) + x2_7_reg;
            x3b_reg <= bpc_pkg::tdiv2(x3b_sum, 2);
            c8_reg  <= c7_reg;

            // stage 9: b3 and b4 product
            b3_reg  <= bpc_pkg::tdiv2(b3_shift + 32'd2, 2);
            b4p_reg <= {16'd0, ac4} * (x3b_reg + bpc_pkg::C_B4_BIAS);
            c9_reg  <= c8_reg;

            // stage 10: b4, b7
            b4_reg  <= b4_s10;
            b7_reg  <= ({13'd0, c9_reg.up} - b3_reg) * scale;
            c10_reg <= '{fault: c9_reg.fault | (b4_s10 == 32'd0),
                         up:    c9_reg.up,
                         b5:    c9_reg.b5};

            // sideband alongside the second divider
            d2c_reg[0] <= c10_reg;
            d2m_reg[0] <= b7_reg[31];

            // stage 11: raw pressure
            p11_reg <= d2m_reg[bpc_pkg::DIV_LAT-1] ? (uq2 << 1) : uq2;
            c11_reg <= d2c_reg[bpc_pkg::DIV_LAT-1];

            // stage 12
            t_reg     <= bpc_pkg::tdiv2(p11_reg, 8);
            m2_12_reg <= bpc_pkg::C_X2_GAIN * p11_reg;
            p12_reg   <= p11_reg;
            c12_reg   <= c11_reg;

            // stage 13
            x1a_reg   <= t_reg * t_reg;
            m2_13_reg <= m2_12_reg;
            p13_reg   <= p12_reg;
            c13_reg   <= c12_reg;

            // stage 14
            x1c_reg   <= x1a_reg * bpc_pkg::C_X1_GAIN;
            m2_14_reg <= m2_13_reg;
            p14_reg   <= p13_reg;
            c14_reg   <= c13_reg;

            // stage 15: output register, faults force zero
            temp_reg  <= c14_reg.fault ? 32'd0 : c14_reg.b5;
            pres_reg  <= c14_reg.fault ? 32'd0 : pn_s15;
            fault_reg <= c14_reg.fault;
        end
    end

    assign out_valid    = v15_reg;
    assign temp_term    = temp_reg;
    assign pressure_pa  = pres_reg;
    assign divide_fault = fault_reg;

endmodule
